// ===== rtl/savgol_path_smoother_assert.svh =====
// Assertion macros shared by the smoother RTL.
// Each macro names the clock and the reset so that a check stays quiet
// while reset is held.
`ifndef SAVGOL_PATH_SMOOTHER_ASSERT_SVH
`define SAVGOL_PATH_SMOOTHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sgps_pkg.sv =====
package sgps_pkg;

   localparam int HALF_SPAN   = 3;
   localparam int WIN         = 2 * HALF_SPAN + 1;
   localparam int POS_W       = $clog2(WIN);
   localparam int COUNT_W     = $clog2(WIN + 1);
   localparam int COORD_W     = 32;
   localparam int COEF_W      = 16;
   localparam int NUM_COEF    = 4;
   localparam int PROD_W      = COORD_W + COEF_W;
   // The adder tree always has eight leaves; unused leaves carry zero.
   localparam int TREE_LEAVES = 8;
   localparam int SUM_W       = PROD_W + $clog2(TREE_LEAVES);
   localparam int FRAC_SHIFT  = 15;
   // Products, three adder levels and the rounding register.
   localparam int LANE_LAT    = 5;
   localparam int LAT_W       = $clog2(LANE_LAT + 1);
   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CENTER = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_ONE    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_TWO    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_THREE  = 8'd3;

   localparam logic signed [COEF_W-1:0] COEF_CENTER_RESET = 16'sd10923;
   localparam logic signed [COEF_W-1:0] COEF_ONE_RESET    = 16'sd9362;
   localparam logic signed [COEF_W-1:0] COEF_TWO_RESET    = 16'sd4681;
   localparam logic signed [COEF_W-1:0] COEF_THREE_RESET  = -16'sd3121;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [WIN-1:0]       window_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef coef_type [NUM_COEF-1:0]   coef_set_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic signed [POS_W+1:0]   spos_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [LAT_W-1:0]          lat_type;

   typedef enum logic {
      ST_IDLE,
      ST_CALC
   } state_type;

   // Sequencer to datapath: which window position to present and how.
   typedef struct packed {
      logic    load;
      logic    pass;
      logic    end_flag;
      pos_type center;
   } emit_type;

   // Window position seen by one tap, with the edges replicated.
   function automatic pos_type tap_pos(pos_type center, int tap);
      spos_type p;
      p = spos_type'({2'b00, center}) + spos_type'(tap - HALF_SPAN);
      if (p < spos_type'(0)) begin
         tap_pos = '0;
      end else if (p > spos_type'(WIN - 1)) begin
         tap_pos = pos_type'(WIN - 1);
      end else begin
         tap_pos = p[POS_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/sgps_if.sv =====
interface sgps_req_if;
   logic                valid;
   logic                ready;
   sgps_pkg::coord_type point_x;
   sgps_pkg::coord_type point_y;
   logic                is_last;

   modport source (output valid, point_x, point_y, is_last, input ready);
   modport sink   (input valid, point_x, point_y, is_last, output ready);
endinterface

interface sgps_rsp_if;
   logic                valid;
   logic                ready;
   sgps_pkg::coord_type smooth_x;
   sgps_pkg::coord_type smooth_y;
   logic                end_of_path;

   modport source (output valid, smooth_x, smooth_y, end_of_path, input ready);
   modport sink   (input valid, smooth_x, smooth_y, end_of_path, output ready);
endinterface

interface sgps_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sgps_pkg::CSR_INDEX_W-1:0]     index;
   sgps_pkg::coef_type                   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/sgps_lane.sv =====
module sgps_lane (
   input  logic                   clock,
   input  sgps_pkg::window_type   win,
   input  sgps_pkg::pos_type      center,
   input  sgps_pkg::coef_set_type coef,
   output sgps_pkg::coord_type    result
);

   localparam int Q_W = sgps_pkg::SUM_W + 1 - sgps_pkg::FRAC_SHIFT;

   typedef logic signed [sgps_pkg::PROD_W-1:0]  prod_type;
   typedef logic signed [sgps_pkg::PROD_W:0]    s1_type;
   typedef logic signed [sgps_pkg::PROD_W+1:0]  s2_type;
   typedef logic signed [sgps_pkg::SUM_W-1:0]   sum_type;
   typedef logic signed [sgps_pkg::SUM_W:0]     rnd_type;
   typedef logic signed [Q_W-1:0]               quo_type;

   localparam rnd_type ROUND_HALF = rnd_type'(1) <<< (sgps_pkg::FRAC_SHIFT - 1);

   prod_type            prod_in [sgps_pkg::TREE_LEAVES];
   prod_type            prod_ff [sgps_pkg::TREE_LEAVES];
   s1_type              s1_ff   [sgps_pkg::TREE_LEAVES/2];
   s2_type              s2_ff   [sgps_pkg::TREE_LEAVES/4];
   sum_type             sum_ff;
   rnd_type             rnd;
   quo_type             quo;
   sgps_pkg::coord_type result_in;
   sgps_pkg::coord_type result_ff;

   // One multiplier per tap; each tap picks its clamped window sample.
   for (genvar t = 0; t < sgps_pkg::TREE_LEAVES; t++) begin : g_tap
      if (t < sgps_pkg::WIN) begin : g_used
         localparam int DIST = (t < sgps_pkg::HALF_SPAN) ?
                               sgps_pkg::HALF_SPAN - t : t - sgps_pkg::HALF_SPAN;
         assign prod_in[t] = prod_type'(coef[DIST]) *
                             prod_type'(win[sgps_pkg::tap_pos(center, t)]);
      end else begin : g_pad
         assign prod_in[t] = '0;
      end
   end

   // Round half up on the Q16.16 grid, then saturate to 32 bits.
   always_comb begin
      rnd = rnd_type'(sum_ff) + ROUND_HALF;
      quo = rnd[sgps_pkg::SUM_W:sgps_pkg::FRAC_SHIFT];
      if ((&quo[Q_W-1:sgps_pkg::COORD_W-1]) || !(|quo[Q_W-1:sgps_pkg::COORD_W-1])) begin
         result_in = quo[sgps_pkg::COORD_W-1:0];
      end else if (quo[Q_W-1]) begin
         result_in = {1'b1, {(sgps_pkg::COORD_W-1){1'b0}}};
      end else begin
         result_in = {1'b0, {(sgps_pkg::COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sgps_pkg::TREE_LEAVES; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      for (int i = 0; i < sgps_pkg::TREE_LEAVES/2; i++) begin
         s1_ff[i] <= s1_type'(prod_ff[2*i]) + s1_type'(prod_ff[2*i+1]);
      end
      for (int i = 0; i < sgps_pkg::TREE_LEAVES/4; i++) begin
         s2_ff[i] <= s2_type'(s1_ff[2*i]) + s2_type'(s1_ff[2*i+1]);
      end
      sum_ff    <= sum_type'(s2_ff[0]) + sum_type'(s2_ff[1]);
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== rtl/sgps_ctrl.sv =====
module sgps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   sgps_req_if.sink             req,
   input  logic                 rsp_free,
   output sgps_pkg::window_type win_x,
   output sgps_pkg::window_type win_y,
   output sgps_pkg::emit_type   emit
);

   sgps_pkg::state_type  state_ff, state_in;
   sgps_pkg::count_type  seen_ff, seen_in, seen_inc;
   logic                 emitted_ff, emitted_in;
   sgps_pkg::pos_type    center_ff, center_in;
   sgps_pkg::pos_type    to_ff, to_in;
   logic                 pass_ff, pass_in;
   logic                 last_ff, last_in;
   sgps_pkg::lat_type    lat_ff, lat_in;
   sgps_pkg::window_type win_x_ff, win_x_in;
   sgps_pkg::window_type win_y_ff, win_y_in;
   logic                 accept;

   assign accept   = req.valid && req.ready;
   assign seen_inc = (seen_ff == sgps_pkg::count_type'(sgps_pkg::WIN)) ?
                     seen_ff : seen_ff + 1'b1;

   // Oldest sample sits at position zero; a new point enters at the top.
   always_comb begin
      win_x_in = win_x_ff;
      win_y_in = win_y_ff;
      if (accept) begin
         for (int k = 0; k < sgps_pkg::WIN - 1; k++) begin
            win_x_in[k] = win_x_ff[k+1];
            win_y_in[k] = win_y_ff[k+1];
         end
         win_x_in[sgps_pkg::WIN-1] = req.point_x;
         win_y_in[sgps_pkg::WIN-1] = req.point_y;
      end
   end

   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      emitted_in    = emitted_ff;
      center_in     = center_ff;
      to_in         = to_ff;
      pass_in       = pass_ff;
      last_in       = last_ff;
      lat_in        = lat_ff;
      req.ready     = (state_ff == sgps_pkg::ST_IDLE);
      emit.load     = 1'b0;
      emit.pass     = pass_ff;
      emit.end_flag = 1'b0;
      emit.center   = center_ff;
      case (state_ff)
         sgps_pkg::ST_IDLE: begin
            if (accept) begin
               seen_in = seen_inc;
               lat_in  = sgps_pkg::lat_type'(sgps_pkg::LANE_LAT);
               last_in = req.is_last;
               pass_in = 1'b0;
               to_in   = sgps_pkg::pos_type'(sgps_pkg::WIN - 1);
               if (req.is_last) begin
                  seen_in    = '0;
                  emitted_in = 1'b0;
                  state_in   = sgps_pkg::ST_CALC;
                  if (seen_inc < sgps_pkg::count_type'(sgps_pkg::WIN)) begin
                     // Short path: hand the stored points back untouched.
                     pass_in   = 1'b1;
                     center_in = sgps_pkg::pos_type'(
                                    sgps_pkg::count_type'(sgps_pkg::WIN) - seen_inc);
                  end else if (!emitted_ff) begin
                     center_in = '0;
                  end else begin
                     center_in = sgps_pkg::pos_type'(sgps_pkg::HALF_SPAN);
                  end
               end else if (seen_inc == sgps_pkg::count_type'(sgps_pkg::WIN)) begin
                  state_in   = sgps_pkg::ST_CALC;
                  emitted_in = 1'b1;
                  to_in      = sgps_pkg::pos_type'(sgps_pkg::HALF_SPAN);
                  center_in  = emitted_ff ? sgps_pkg::pos_type'(sgps_pkg::HALF_SPAN) : '0;
               end
            end
         end
         sgps_pkg::ST_CALC: begin
            if (lat_ff != '0) begin
               lat_in = lat_ff - 1'b1;
            end else if (rsp_free) begin
               emit.load     = 1'b1;
               emit.end_flag = last_ff && (center_ff == to_ff);
               lat_in        = sgps_pkg::lat_type'(sgps_pkg::LANE_LAT);
               if (center_ff == to_ff) begin
                  state_in = sgps_pkg::ST_IDLE;
               end else begin
                  center_in = center_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = sgps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sgps_pkg::ST_IDLE;
         seen_ff    <= '0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         seen_ff    <= seen_in;
         emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      to_ff     <= to_in;
      pass_ff   <= pass_in;
      last_ff   <= last_in;
      lat_ff    <= lat_in;
      win_x_ff  <= win_x_in;
      win_y_ff  <= win_y_in;
   end

   assign win_x = win_x_ff;
   assign win_y = win_y_ff;

endmodule

// ===== rtl/savgol_path_smoother.sv =====
// Seven-point Savitzky-Golay path smoother. Path points arrive one beat at a
// time on req_ch (signed Q16.16 x and y plus a last-point mark) and smoothed
// points leave on rsp_ch, lagging the input by three points; the last point of
// a path flushes every remaining output, and the final output beat carries
// end_of_path. Paths shorter than seven points come back unchanged. Samples
// beyond either end of the path are replaced by the first or last point. The
// kernel is symmetric and comes from four signed Q1.15 registers written over
// csr_ch (index 0 center, 1 to 3 the taps at distance one to three; other
// indexes are ignored); they reset to the quadratic seven-point weights. Each
// output is rounded half up to Q16.16 and saturated to 32 bits. A point is
// taken while the sequencer is idle, and every output it causes then passes
// through the five-register lane pipeline (tap multipliers, three adder
// levels, rounding) and the load into the output register, with one output in
// flight at a time; a load waits while rsp_ch stalls. The next point may be
// taken while the last result still waits in the output register. Coefficient
// writes are taken only while req_ch.ready is high, so csr_ch.ready follows it.
`include "savgol_path_smoother_assert.svh"

module savgol_path_smoother (
   input  logic       clock,
   input  logic       reset,
   sgps_req_if.sink   req_ch,
   sgps_rsp_if.source rsp_ch,
   sgps_csr_if.sink   csr_ch
);

   sgps_pkg::coef_set_type coef_ff, coef_in;
   sgps_pkg::window_type   win_x;
   sgps_pkg::window_type   win_y;
   sgps_pkg::emit_type     emit;
   sgps_pkg::coord_type    lane_x;
   sgps_pkg::coord_type    lane_y;
   logic                   rsp_free;

   logic                   rsp_valid_ff, rsp_valid_in;
   sgps_pkg::coord_type    rsp_x_ff, rsp_x_in;
   sgps_pkg::coord_type    rsp_y_ff, rsp_y_in;
   logic                   rsp_end_ff, rsp_end_in;

   // The output register can take a new beat when empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // The sequencer owns the sample windows, the path counters and the order
   // in which window positions are presented to the lanes.
   sgps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp_free (rsp_free),
      .win_x    (win_x),
      .win_y    (win_y),
      .emit     (emit)
   );

   // One lane per coordinate; both see the same center and kernel.
   sgps_lane u_lane_x (
      .clock  (clock),
      .win    (win_x),
      .center (emit.center),
      .coef   (coef_ff),
      .result (lane_x)
   );

   sgps_lane u_lane_y (
      .clock  (clock),
      .win    (win_y),
      .center (emit.center),
      .coef   (coef_ff),
      .result (lane_y)
   );

   // Coefficient registers. Writes are only allowed while the sequencer is idle,
   // which keeps the kernel fixed while the lanes are busy.
   assign csr_ch.ready = req_ch.ready;

   always_comb begin
      coef_in = coef_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            sgps_pkg::CSR_COEF_CENTER: coef_in[0] = csr_ch.wdata;
            sgps_pkg::CSR_COEF_ONE:    coef_in[1] = csr_ch.wdata;
            sgps_pkg::CSR_COEF_TWO:    coef_in[2] = csr_ch.wdata;
            sgps_pkg::CSR_COEF_THREE:  coef_in[3] = csr_ch.wdata;
            default: begin
            end
         endcase
      end
   end

   // Merge stage: pick the lane results or, for a short path, the raw
   // window samples, and park the beat in the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_end_in   = rsp_end_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit.load) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = emit.pass ? win_x[emit.center] : lane_x;
         rsp_y_in     = emit.pass ? win_y[emit.center] : lane_y;
         rsp_end_in   = emit.end_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]   <= sgps_pkg::COEF_CENTER_RESET;
         coef_ff[1]   <= sgps_pkg::COEF_ONE_RESET;
         coef_ff[2]   <= sgps_pkg::COEF_TWO_RESET;
         coef_ff[3]   <= sgps_pkg::COEF_THREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.smooth_x    = rsp_x_ff;
   assign rsp_ch.smooth_y    = rsp_y_ff;
   assign rsp_ch.end_of_path = rsp_end_ff;

   // The sequencer must never overwrite a beat that has not been taken.
   `SGPS_ASSERT_SAME(a_load_into_free_slot, clock, reset, emit.load, rsp_free, "output beat overwritten")
   // The kernel must not move while outputs are being computed.
   `SGPS_ASSERT_NEXT(a_coef_hold_busy, clock, reset, !req_ch.ready, $stable(coef_ff), "kernel changed while busy")
   // The end-of-path beat closes the item and frees the input side.
   `SGPS_ASSERT_NEXT(a_end_frees_input, clock, reset, emit.load && emit.end_flag, req_ch.ready, "busy after end of path")

endmodule
